### rtl/atpq_pkg.sv
// atpq_pkg: item types shared by the armed toggle pulse qualifier
// no dependencies; imported by atpq_frame and armed_toggle_pulse_qualifier
package atpq_pkg;

	localparam int unsigned TotalWidth = 32;
	localparam int unsigned PctScale   = 100;
	localparam int unsigned PctThresh  = 49;

	typedef struct packed {
		logic step_active;
		logic enable_cmd;
		logic toggle_cmd;
		logic frame_last;
	} in_item_t;

	typedef struct packed {
		logic                  toggle_out;
		logic                  enable_out;
		logic [TotalWidth-1:0] pulse_total;
	} out_item_t;

	// control from the top level into the frame accumulator
	typedef struct packed {
		logic clear;
		logic update;
		logic enable;
		logic pulse;
		logic last;
	} frame_ctl_t;

	// frame accumulator view of the sample being processed
	typedef struct packed {
		logic close;
		logic parity;
		logic pass;
	} frame_res_t;

endpackage

### rtl/atpq_frame.sv
// atpq_frame: per-frame counters and enable threshold decision for queued mode
// depends on atpq_pkg
module atpq_frame #(
	parameter int unsigned MAX_FRAME = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  atpq_pkg::frame_ctl_t ctl,
	output atpq_pkg::frame_res_t res
);
	import atpq_pkg::*;

	localparam int unsigned CW = $clog2(MAX_FRAME + 1);
	localparam int unsigned PW = CW + 7;

	logic [CW-1:0] len_q;
	logic [CW-1:0] ena_q;
	logic          par_q;

	logic [CW-1:0] len_nxt;
	logic [CW-1:0] ena_nxt;
	logic          par_nxt;
	logic [PW-1:0] ena_scaled;
	logic [PW-1:0] len_scaled;

	// the length is below MAX_FRAME between samples, so the increment never wraps
	assign len_nxt = len_q + CW'(1);
	assign ena_nxt = ena_q + CW'(ctl.enable);
	assign par_nxt = par_q ^ ctl.pulse;

	assign ena_scaled = PW'(ena_nxt) * PW'(PctScale);
	assign len_scaled = PW'(len_nxt) * PW'(PctThresh);

	assign res.close  = ctl.last || (len_nxt == CW'(MAX_FRAME));
	assign res.parity = par_nxt;
	assign res.pass   = par_nxt || (ena_scaled >= len_scaled);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ena_q <= '0;
			par_q <= 1'b0;
		end else if (ctl.clear || (ctl.update && res.close)) begin
			len_q <= '0;
			ena_q <= '0;
			par_q <= 1'b0;
		end else if (ctl.update) begin
			len_q <= len_nxt;
			ena_q <= ena_nxt;
			par_q <= par_nxt;
		end
	end

endmodule

### rtl/armed_toggle_pulse_qualifier.sv
// armed_toggle_pulse_qualifier: top level, arm/re-arm qualification and result register
// depends on atpq_pkg and atpq_frame
//
//  channel  | handshake              | word
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_ready    | in_data  (step, enable, toggle, last)
//  out      | out_valid / out_ready  | out_data (toggle, enable, pulse total)
//  cfg      | cfg_we                 | cfg_data (queued_mode)
//
// one word per cycle sustained while the result register is empty or out_ready is high;
// a word passes the input register and then the result register.
// in_ready drops only while both registers are full and out_ready is low.
// reset arms the block, clears the total and frame counters, selects direct mode.
module armed_toggle_pulse_qualifier #(
	parameter int unsigned MAX_FRAME = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  atpq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output atpq_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_data
);
	import atpq_pkg::*;

	in_item_t              item_s1;
	logic                  valid_s1;
	logic                  queued_q;
	logic                  armed_q;
	logic [TotalWidth-1:0] total_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic                  advance;
	logic                  live;
	logic                  pulse;
	logic                  armed_nxt;
	logic [TotalWidth-1:0] total_nxt;
	logic                  emit;
	frame_ctl_t            fctl;
	frame_res_t            fres;
	out_item_t             result;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign live     = advance && item_s1.step_active;

	// arm/re-arm rule
	always_comb begin
		pulse     = armed_q && item_s1.toggle_cmd && item_s1.enable_cmd;
		armed_nxt = armed_q;
		if (pulse) begin
			armed_nxt = 1'b0;
		end else if (!armed_q && !item_s1.toggle_cmd && item_s1.enable_cmd) begin
			armed_nxt = 1'b1;
		end
	end

	assign total_nxt = total_q + TotalWidth'(pulse);

	assign fctl.clear  = cfg_we;
	assign fctl.update = live && queued_q;
	assign fctl.enable = item_s1.enable_cmd;
	assign fctl.pulse  = pulse;
	assign fctl.last   = item_s1.frame_last;

	atpq_frame #(
		.MAX_FRAME(MAX_FRAME)
	) u_frame (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (fctl),
		.res   (fres)
	);

	assign emit = live && (!queued_q || fres.close);

	always_comb begin
		result.pulse_total = total_nxt;
		if (queued_q) begin
			result.toggle_out = fres.parity;
			result.enable_out = fres.pass;
		end else begin
			result.toggle_out = pulse;
			result.enable_out = item_s1.enable_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q <= 1'b0;
			armed_q  <= 1'b1;
			total_q  <= '0;
		end else begin
			if (cfg_we) begin
				queued_q <= cfg_data;
			end
			if (live) begin
				armed_q <= armed_nxt;
				total_q <= total_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// a reported toggle always carries enable
	a_toggle_implies_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.toggle_out |-> out_q.enable_out)
		else $error("toggle reported without enable");

	// disarming only happens on a processed sample
	a_disarm_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(armed_q) |-> $past(live))
		else $error("armed cleared without a processed sample");

	// the total only ever moves up by one
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != $past(total_q) |-> total_q == $past(total_q) + TotalWidth'(1))
		else $error("pulse total jumped");
`endif

endmodule

### test/armed_toggle_pulse_qualifier_tb.sv
// armed_toggle_pulse_qualifier_tb: self-checking bench for the armed toggle pulse qualifier
// depends on atpq_pkg and armed_toggle_pulse_qualifier; predicts every result word and
// checks it in order while both channels idle and stall at random
module armed_toggle_pulse_qualifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atpq_pkg::*;

	localparam int unsigned FRAME_CAP      = 16;
	localparam bit          MODE_DIRECT    = 1'b0;
	localparam bit          MODE_QUEUED    = 1'b1;
	localparam int unsigned DRAIN_CYCLES   = 6;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned REPORT_LIMIT   = 10;

	// predicts result words from accepted input words and checks them in order
	class toggle_result_board;
		bit          queued;
		bit          armed;
		bit [31:0]   total;
		bit [4:0]    frame_pulses;
		bit [4:0]    frame_enables;
		bit [4:0]    frame_len;
		out_item_t   pending_results[$];
		int unsigned errors;
		int unsigned words_seen;
		int unsigned ignored;
		int unsigned results_seen;
		int unsigned pulses;
		int unsigned frames_by_last;
		int unsigned frames_by_cap;
		int unsigned mode_writes;

		function new();
			queued = MODE_DIRECT;
			armed  = 1'b1;
			total  = '0;
			clear_frame();
		endfunction

		function void clear_frame();
			frame_pulses  = '0;
			frame_enables = '0;
			frame_len     = '0;
		endfunction

		function void apply_mode(bit m);
			queued = m;
			mode_writes++;
			clear_frame();
		endfunction

		function void note_sample(in_item_t s);
			bit        pulse;
			out_item_t r;
			words_seen++;
			if (!s.step_active) begin
				ignored++;
				return;
			end
			pulse = 1'b0;
			// armed pulse counts and disarms, enabled quiet sample re-arms
			if (armed && s.toggle_cmd && s.enable_cmd) begin
				armed = 1'b0;
				pulse = 1'b1;
			end else if (!armed && !s.toggle_cmd && s.enable_cmd) begin
				armed = 1'b1;
			end
			total  = total + pulse;
			pulses += pulse;
			if (queued == MODE_DIRECT) begin
				r.toggle_out  = pulse;
				r.enable_out  = s.enable_cmd;
				r.pulse_total = total;
				pending_results.push_back(r);
				return;
			end
			frame_pulses  += pulse;
			frame_enables += s.enable_cmd;
			frame_len     += 5'd1;
			if (!s.frame_last && frame_len < FRAME_CAP)
				return;
			if (s.frame_last)
				frames_by_last++;
			else
				frames_by_cap++;
			r.toggle_out  = frame_pulses[0];
			r.enable_out  = r.toggle_out ||
				(int'(frame_enables) * PctScale >= int'(frame_len) * PctThresh);
			r.pulse_total = total;
			pending_results.push_back(r);
			clear_frame();
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("result %0d arrived with nothing expected: toggle %b enable %b total %0d",
						results_seen, got.toggle_out, got.enable_out, got.pulse_total);
				return;
			end
			want = pending_results.pop_front();
			if (got.toggle_out !== want.toggle_out || got.enable_out !== want.enable_out ||
					got.pulse_total !== want.pulse_total) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("result %0d mismatch: toggle %b/%b enable %b/%b total %0d/%0d (exp/got)",
						results_seen, want.toggle_out, got.toggle_out, want.enable_out,
						got.enable_out, want.pulse_total, got.pulse_total);
			end
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

		function void close_out();
			if (pending_results.size() != 0) begin
				errors += pending_results.size();
				$display("%0d expected results never arrived", pending_results.size());
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic      cfg_data;

	toggle_result_board board;
	int unsigned burst_left    = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served   = 0;
	int unsigned hold_left     = 0;
	int unsigned rcv_span      = 0;
	int unsigned rcv_style     = 0;
	int unsigned stall_run     = 0;
	int unsigned longest_stall = 0;
	int unsigned idle_run      = 0;

	armed_toggle_pulse_qualifier #(
		.MAX_FRAME(FRAME_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: changing ready patterns, plus long holds on request
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left = HOLD_CYCLES;
			hold_served++;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			if (rcv_span == 0) begin
				rcv_style = $urandom_range(0, 3);
				rcv_span  = $urandom_range(16, 128);
			end
			rcv_span--;
			case (rcv_style)
				0: out_ready = 1'b1;
				1: out_ready = 1'($urandom_range(0, 1));
				2: out_ready = ($urandom_range(0, 3) == 0);
				default: out_ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// check results before noting inputs; a word accepted now cannot show up yet
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(out_data);
			if (in_valid && in_ready)
				board.note_sample(in_data);
			if (in_valid && !in_ready) begin
				stall_run++;
				if (stall_run > longest_stall)
					longest_stall = stall_run;
			end else begin
				stall_run = 0;
			end
		end
	end

	initial begin
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic in_item_t sample(bit step, bit en, bit tg, bit last);
		in_item_t w;
		w.step_active = step;
		w.enable_cmd  = en;
		w.toggle_cmd  = tg;
		w.frame_last  = last;
		return w;
	endfunction

	function automatic in_item_t random_sample(int unsigned en_pct, bit last);
		return sample(1'b1, $urandom_range(0, 99) < en_pct, 1'($urandom_range(0, 1)), last);
	endfunction

	// step low: block must drop it whatever the other bits say
	function automatic in_item_t noise_word();
		return sample(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	task automatic offer(in_item_t w);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) :
				$urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		in_data  = w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		settle();
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = m;
		@(negedge clk);
		cfg_we   = 1'b0;
		board.apply_mode(m);
	endtask

	task automatic run_direct(int unsigned n, bit with_hold);
		int unsigned en_pct;
		en_pct = 60;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 20 == 0)
				en_pct = $urandom_range(10, 95);
			if (with_hold && i == 20)
				hold_requests++;
			if ($urandom_range(0, 9) == 0)
				offer(noise_word());
			offer(random_sample(en_pct, 1'($urandom_range(0, 1))));
		end
	endtask

	// mostly well-formed frames; broken ones reach or run past the cap with no last flag
	task automatic run_frames(int unsigned n, int unsigned broken_pct);
		int unsigned sent;
		int unsigned len;
		int unsigned en_pct;
		bit          broken;
		sent = 0;
		while (sent < n) begin
			broken = ($urandom_range(0, 99) < broken_pct);
			if (broken)
				len = $urandom_range(FRAME_CAP, FRAME_CAP + 8);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(9, FRAME_CAP);
			else
				len = $urandom_range(1, 8);
			case ($urandom_range(0, 2))
				0: en_pct = $urandom_range(0, 30);
				1: en_pct = $urandom_range(40, 60);
				default: en_pct = $urandom_range(70, 100);
			endcase
			for (int unsigned i = 0; i < len; i++) begin
				if ($urandom_range(0, 11) == 0)
					offer(noise_word());
				offer(random_sample(en_pct, !broken && i == len - 1));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_data  = 1'b0;
		board     = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// direct: ignored step, pulse, blocked repeat, no re-arm without enable, re-arm, pulse again
		write_mode(MODE_DIRECT);
		offer(sample(1'b0, 1'b1, 1'b1, 1'b1));
		offer(sample(1'b1, 1'b1, 1'b1, 1'b0));
		offer(sample(1'b1, 1'b1, 1'b1, 1'b1));
		offer(sample(1'b1, 1'b0, 1'b0, 1'b0));
		offer(sample(1'b1, 1'b0, 1'b1, 1'b0));
		offer(sample(1'b1, 1'b1, 1'b0, 1'b1));
		offer(sample(1'b1, 1'b1, 1'b1, 1'b0));

		// queued: single-word frame, quiet two-word frame, stream hitting the cap
		write_mode(MODE_QUEUED);
		offer(sample(1'b1, 1'b1, 1'b0, 1'b1));
		offer(sample(1'b1, 1'b0, 1'b1, 1'b0));
		offer(sample(1'b1, 1'b0, 1'b0, 1'b1));
		for (int unsigned i = 0; i < FRAME_CAP; i++)
			offer(sample(1'b1, i % 3 != 0, i[0], 1'b0));
		// partial frame dropped by rewriting the same mode
		offer(sample(1'b1, 1'b1, 1'b1, 1'b0));
		offer(sample(1'b1, 1'b1, 1'b0, 1'b0));
		write_mode(MODE_QUEUED);
		offer(sample(1'b1, 1'b0, 1'b0, 1'b1));

		write_mode(MODE_DIRECT);
		run_direct(300, 1'b1);
		write_mode(MODE_QUEUED);
		run_frames(400, 5);
		write_mode(MODE_DIRECT);
		run_direct(200, 1'b0);
		write_mode(MODE_QUEUED);
		run_frames(300, 25);
		for (int unsigned i = 0; i < $urandom_range(1, FRAME_CAP - 1); i++)
			offer(random_sample(50, 1'b0));
		write_mode(MODE_QUEUED);
		run_frames(100, 10);
		write_mode(MODE_DIRECT);
		run_direct(50, 1'b0);

		settle();
		board.close_out();
		$display("%0d input words (%0d ignored), %0d results, %0d pulses, %0d mode writes",
			board.words_seen, board.ignored, board.results_seen, board.pulses,
			board.mode_writes);
		$display("frames closed by last %0d, by cap %0d; longest input stall %0d cycles",
			board.frames_by_last, board.frames_by_cap, longest_stall);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
